// ----- sv/longest_prefix_match_route_lookup_assert.svh -----
// Assertion macros shared by the route lookup RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef LONGEST_PREFIX_MATCH_ROUTE_LOOKUP_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_ROUTE_LOOKUP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LPM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("route lookup check failed");

// Next-cycle implication, checked outside reset.
`define LPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("route lookup check failed");

`endif

// ----- sv/lpm_pkg.sv -----
// ----------------------------------------------------------------------------
// lpm_pkg
// Types and constants shared by the longest-prefix-match route lookup.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // Fixed field widths.
  localparam int ADDR_W = 32;
  localparam int PORT_W = 4;
  localparam int SLOT_W = 6;

  // Item opcodes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // One route table entry as stored in memory.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
  } route_entry_t;

  // Controls from the sequencer to the match tracker.
  typedef struct packed {
    logic              clear;
    logic              cmp_en;
    logic [SLOT_W-1:0] slot;
  } scan_ctl_t;

  // Lookup result.
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] next_hop;
    logic [PORT_W-1:0] port;
    logic [SLOT_W-1:0] slot;
  } match_result_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } lpm_state_t;

endpackage

// ----- sv/longest_prefix_match_route_lookup.sv -----
// ----------------------------------------------------------------------------
// longest_prefix_match_route_lookup
// IPv4 route table with longest-prefix-match lookup over a scanned memory.
// ----------------------------------------------------------------------------
// Usage: the input channel carries write items (opcode 0), which load or
// invalidate one table slot, and lookup items (opcode 1), which route one
// address. Each transfer is valid high and stall low at a rising edge.
// A write gives no result. A lookup reads the table one slot per cycle
// through the memory's single read port and compares each entry as it is
// read; once the last comparison is done the result is loaded into the
// output register, and only then is the next item taken.
// The result sits in an output register; while the receiver stalls it holds,
// and the next item may still be taken and worked on. A finished lookup waits
// for that register to empty before it completes.
// After reset the block clears the valid bit of every slot, one slot per
// cycle, with in_stall high; then the table is empty and every lookup
// returns found = 0 with zero fields.
// Writes to a slot at or beyond TABLE_DEPTH are dropped.
// ----------------------------------------------------------------------------
`include "longest_prefix_match_route_lookup_assert.svh"

module longest_prefix_match_route_lookup import lpm_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [SLOT_W-1:0] in_entry_index,
  input  logic              in_entry_valid,
  input  logic [ADDR_W-1:0] in_entry_prefix,
  input  logic [ADDR_W-1:0] in_entry_mask,
  input  logic [ADDR_W-1:0] in_entry_gateway,
  input  logic [PORT_W-1:0] in_entry_port,
  input  logic [ADDR_W-1:0] in_lookup_addr,
  // Result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic [ADDR_W-1:0] out_next_hop,
  output logic [PORT_W-1:0] out_out_port,
  output logic [SLOT_W-1:0] out_match_slot
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

  lpm_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              rd_valid_r;
  logic [IDX_W-1:0]  rd_slot_r;
  logic              out_valid_r;
  match_result_t     out_r;

  logic              in_xfer;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  route_entry_t      wr_data;
  logic              rd_en;
  route_entry_t      rd_data;
  scan_ctl_t         ctl;
  match_result_t     best;
  logic              out_load;

  // Items are taken only while idle; the scan owns the memory otherwise.
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Memory write: clearing pass after reset, or a write item in range.
  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = cnt_r;
    wr_data.valid   = 1'b0;
    wr_data.prefix  = in_entry_prefix;
    wr_data.mask    = in_entry_mask;
    wr_data.gateway = in_entry_gateway;
    wr_data.port    = in_entry_port;
    if (state_r == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (in_xfer && (in_opcode == OP_WRITE) &&
                 (32'(in_entry_index) < TABLE_DEPTH)) begin
      wr_en         = 1'b1;
      wr_addr       = IDX_W'(in_entry_index);
      wr_data.valid = in_entry_valid;
    end
  end

  assign rd_en    = (state_r == ST_SCAN);
  assign out_load = (state_r == ST_FINISH) && !rd_valid_r && (!out_valid_r || !out_stall);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_SLOT) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer && (in_opcode == OP_LOOKUP)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_SLOT) begin
          cnt_nxt   = '0;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rd_valid_r <= rd_en;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot tag that travels with the read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_slot_r <= cnt_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= best;
    end
  end

  assign ctl.clear  = in_xfer && (in_opcode == OP_LOOKUP);
  assign ctl.cmp_en = rd_valid_r;
  assign ctl.slot   = SLOT_W'(rd_slot_r);

  lpm_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  lpm_scan u_scan (
    .clk         (clk),
    .ctl         (ctl),
    .lookup_addr (in_lookup_addr),
    .entry       (rd_data),
    .best        (best)
  );

  assign out_valid      = out_valid_r;
  assign out_found      = out_r.found;
  assign out_next_hop   = out_r.next_hop;
  assign out_out_port   = out_r.port;
  assign out_match_slot = out_r.slot;

  // The table is never written while a lookup is reading it.
  `LPM_ASSERT_IMP(a_no_write_in_scan, (state_r == ST_SCAN) || (state_r == ST_FINISH), !wr_en)
  // Read data is only compared in the cycle after a read was issued.
  `LPM_ASSERT_NEXT(a_cmp_follows_read, rd_en, rd_valid_r)
  // A result is only loaded once the last comparison has finished.
  `LPM_ASSERT_NEXT(a_load_after_scan, out_load, !rd_valid_r && (state_r == ST_IDLE))
  // A miss reports all-zero fields.
  `LPM_ASSERT_IMP(a_miss_is_zero, out_valid_r && !out_r.found,
                  (out_r.next_hop == '0) && (out_r.port == '0) && (out_r.slot == '0))

endmodule

// ----- sv/lpm_table.sv -----
// ----------------------------------------------------------------------------
// lpm_table
// Route table memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module lpm_table import lpm_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  route_entry_t  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output route_entry_t  rd_data
);

  route_entry_t mem_r [DEPTH];
  route_entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/lpm_scan.sv -----
// ----------------------------------------------------------------------------
// lpm_scan
// Match tracker: compares each entry read from the table against the lookup
// address and keeps the best match seen so far.
// ----------------------------------------------------------------------------
module lpm_scan import lpm_pkg::*; (
  input  logic              clk,
  input  scan_ctl_t         ctl,
  input  logic [ADDR_W-1:0] lookup_addr,
  input  route_entry_t      entry,
  output match_result_t     best
);

  logic [ADDR_W-1:0] addr_r;
  logic              hit_r;
  logic [ADDR_W-1:0] best_mask_r;
  logic [ADDR_W-1:0] gw_r;
  logic [PORT_W-1:0] port_r;
  logic [SLOT_W-1:0] slot_r;
  logic              match;
  logic              take;

  // An entry matches when prefix and address agree on every mask bit.
  assign match = entry.valid && (((entry.prefix ^ addr_r) & entry.mask) == '0);
  // Ties go to the later slot, so an equal mask replaces the best.
  assign take  = ctl.cmp_en && match && (!hit_r || (entry.mask >= best_mask_r));

  // Best-match registers; a clear starts a new lookup with an all-zero result.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      addr_r      <= lookup_addr;
      hit_r       <= 1'b0;
      best_mask_r <= '0;
      gw_r        <= '0;
      port_r      <= '0;
      slot_r      <= '0;
    end else if (take) begin
      hit_r       <= 1'b1;
      best_mask_r <= entry.mask;
      gw_r        <= entry.gateway;
      port_r      <= entry.port;
      slot_r      <= ctl.slot;
    end
  end

  assign best.found    = hit_r;
  assign best.next_hop = gw_r;
  assign best.port     = port_r;
  assign best.slot     = slot_r;

endmodule
